FILE: src/eitp_pkg.sv
`default_nettype none

package eitp_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_TAG     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_IGNORE  = 3'd4
  } eitp_phase_t;

  // Field tags as held internally
  typedef enum logic [2:0] {
    TG_VERSION  = 3'd0,
    TG_SKIP     = 3'd1,
    TG_PRODUCT  = 3'd2,
    TG_TIME     = 3'd3,
    TG_ASSEMBLY = 3'd4,
    TG_IMEI     = 3'd5
  } eitp_tag_t;

  // Result kinds
  typedef enum logic [3:0] {
    K_VERSION  = 4'd0,
    K_PRODUCT  = 4'd1,
    K_TIME     = 4'd2,
    K_ASSEMBLY = 4'd3,
    K_IMEI     = 4'd4,
    K_ENDTAG   = 4'd5,
    K_ENDBUF   = 4'd6,
    K_TRUNC    = 4'd7,
    K_BADVER   = 4'd8
  } eitp_kind_t;

  // Tag byte codes in the image
  localparam logic [7:0] TAG_BYTE_VERSION  = 8'h00;
  localparam logic [7:0] TAG_BYTE_SKIP     = 8'h09;
  localparam logic [7:0] TAG_BYTE_PRODUCT  = 8'h14;
  localparam logic [7:0] TAG_BYTE_TIME     = 8'h1B;
  localparam logic [7:0] TAG_BYTE_ASSEMBLY = 8'h24;
  localparam logic [7:0] TAG_BYTE_IMEI     = 8'h37;

  // Header byte values
  localparam logic [7:0] HDR_BYTE0 = 8'h00;
  localparam logic [7:0] HDR_BYTE1 = 8'h01;

  localparam logic [3:0] BCD_LIMIT  = 4'hA;
  localparam int unsigned MAX_DIGITS = 16;

  // One result beat
  typedef struct packed {
    eitp_kind_t  kind;
    logic [31:0] major;
    logic [15:0] minor;
    logic [63:0] digits;
    logic [4:0]  count;
    logic        last;
  } eitp_res_t;

  // Results caused by one accepted byte, in order
  typedef struct packed {
    logic [1:0] n;
    eitp_res_t  r0;
    eitp_res_t  r1;
  } eitp_push_t;

endpackage

`default_nettype wire

FILE: src/eitp_parse.sv
`default_nettype none

module eitp_parse
  import eitp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output eitp_push_t      push
);

  eitp_phase_t phase_r, phase_nxt;
  eitp_tag_t   tag_r, tag_nxt;
  logic [3:0]  left_r, left_nxt;
  logic [39:0] accum_r, accum_nxt;
  logic [63:0] dstore_r, dstore_nxt;
  logic [4:0]  kept_r, kept_nxt;

  logic [3:0]  left_dec;
  logic        done;
  logic        tag_known;
  eitp_tag_t   tag_dec;
  logic [3:0]  len_dec;
  logic [39:0] accum_sh;
  logic [3:0]  hi_nib, lo_nib;
  logic        hi_ok, lo_ok;
  logic [4:0]  kept_a, kept_b;
  logic [63:0] dstore_ins;

  // Field result and status result
  logic       fv, sv;
  eitp_res_t  fres, sres;

  // Decode tag byte
  always_comb begin
    tag_known = 1'b1;
    tag_dec   = TG_VERSION;
    len_dec   = 4'd0;
    unique case (data_byte)
      TAG_BYTE_VERSION:  begin tag_dec = TG_VERSION;  len_dec = 4'd1; end
      TAG_BYTE_SKIP:     begin tag_dec = TG_SKIP;     len_dec = 4'd2; end
      TAG_BYTE_PRODUCT:  begin tag_dec = TG_PRODUCT;  len_dec = 4'd5; end
      TAG_BYTE_TIME:     begin tag_dec = TG_TIME;     len_dec = 4'd4; end
      TAG_BYTE_ASSEMBLY: begin tag_dec = TG_ASSEMBLY; len_dec = 4'd5; end
      TAG_BYTE_IMEI:     begin tag_dec = TG_IMEI;     len_dec = 4'd8; end
      default:           tag_known = 1'b0;
    endcase
  end

  // Payload byte: shift accumulator, count down
  assign accum_sh = {accum_r[31:0], data_byte};
  assign left_dec = (left_r != 4'd0) ? left_r - 4'd1 : 4'd0;
  assign done     = (left_dec == 4'd0);

  // Keep BCD digits, high nibble first
  assign hi_nib = data_byte[7:4];
  assign lo_nib = data_byte[3:0];
  assign hi_ok  = (hi_nib < BCD_LIMIT) && (kept_r < 5'(MAX_DIGITS));
  assign kept_a = kept_r + {4'd0, hi_ok};
  assign lo_ok  = (lo_nib < BCD_LIMIT) && (kept_a < 5'(MAX_DIGITS));
  assign kept_b = kept_a + {4'd0, lo_ok};

  always_comb begin
    dstore_ins = dstore_r;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (hi_ok && (kept_r == 5'(i))) begin
        dstore_ins[63 - 4*i -: 4] = hi_nib;
      end else if (lo_ok && (kept_a == 5'(i))) begin
        dstore_ins[63 - 4*i -: 4] = lo_nib;
      end
    end
  end

  // Next state
  always_comb begin
    phase_nxt  = phase_r;
    tag_nxt    = tag_r;
    left_nxt   = left_r;
    accum_nxt  = accum_r;
    dstore_nxt = dstore_r;
    kept_nxt   = kept_r;
    unique case (phase_r)
      PH_HDR0: begin
        phase_nxt = (data_byte != HDR_BYTE0) ? PH_IGNORE : PH_HDR1;
      end
      PH_HDR1: begin
        phase_nxt = (data_byte != HDR_BYTE1) ? PH_IGNORE : PH_TAG;
      end
      PH_TAG: begin
        accum_nxt  = '0;
        dstore_nxt = '0;
        kept_nxt   = '0;
        left_nxt   = len_dec;
        if (tag_known) begin
          tag_nxt   = tag_dec;
          phase_nxt = PH_PAYLOAD;
        end else begin
          phase_nxt = PH_IGNORE;
        end
      end
      PH_PAYLOAD: begin
        accum_nxt = accum_sh;
        left_nxt  = left_dec;
        if (tag_r == TG_IMEI) begin
          dstore_nxt = dstore_ins;
          kept_nxt   = kept_b;
        end
        if (done) begin
          phase_nxt = PH_TAG;
        end
      end
      default: ;
    endcase
  end

  // Results for this byte
  always_comb begin
    fv   = 1'b0;
    sv   = 1'b0;
    fres = '0;
    sres = '0;
    unique case (phase_r)
      PH_HDR0: begin
        if (data_byte != HDR_BYTE0) begin
          sv = 1'b1; sres.kind = K_BADVER;
        end else if (last_byte) begin
          sv = 1'b1; sres.kind = K_TRUNC;
        end
      end
      PH_HDR1: begin
        if (data_byte != HDR_BYTE1) begin
          sv = 1'b1; sres.kind = K_BADVER;
        end else begin
          fv = 1'b1; fres.kind = K_VERSION; fres.major = 32'd1;
          if (last_byte) begin
            sv = 1'b1; sres.kind = K_ENDBUF;
          end
        end
      end
      PH_TAG: begin
        if (!tag_known) begin
          sv = 1'b1; sres.kind = K_ENDTAG;
        end else if (last_byte) begin
          sv = 1'b1; sres.kind = K_TRUNC;
        end
      end
      PH_PAYLOAD: begin
        if (done) begin
          case (tag_r)
            TG_VERSION: begin
              fv = 1'b1; fres.kind = K_VERSION; fres.major = {24'd0, accum_sh[7:0]};
            end
            TG_PRODUCT: begin
              fv = 1'b1; fres.kind = K_PRODUCT;
              fres.major = {8'd0, accum_sh[39:16]};
              fres.minor = accum_sh[15:0];
            end
            TG_TIME: begin
              fv = 1'b1; fres.kind = K_TIME;
              fres.major = {accum_sh[7:0], accum_sh[15:8], accum_sh[23:16], accum_sh[31:24]};
            end
            TG_ASSEMBLY: begin
              fv = 1'b1; fres.kind = K_ASSEMBLY;
              fres.major = {8'd0, accum_sh[39:16]};
              fres.minor = accum_sh[15:0];
            end
            TG_IMEI: begin
              fv = 1'b1; fres.kind = K_IMEI;
              fres.digits = dstore_ins;
              fres.count  = kept_b;
            end
            default: ;
          endcase
          if (last_byte) begin
            sv = 1'b1; sres.kind = K_ENDBUF;
          end
        end else if (last_byte) begin
          sv = 1'b1; sres.kind = K_TRUNC;
        end
      end
      default: ;
    endcase
    fres.last = !sv;
    sres.last = 1'b1;
  end

  // Order the beats: field result first, then status
  always_comb begin
    push.n  = {1'b0, fv} + {1'b0, sv};
    push.r0 = fv ? fres : sres;
    push.r1 = sres;
    if (!accept) begin
      push.n = 2'd0;
    end
  end

  // Hold parser state; re-arm after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      tag_r    <= TG_VERSION;
      left_r   <= '0;
      accum_r  <= '0;
      dstore_r <= '0;
      kept_r   <= '0;
    end else if (accept) begin
      if (last_byte) begin
        phase_r  <= PH_HDR0;
        tag_r    <= TG_VERSION;
        left_r   <= '0;
        accum_r  <= '0;
        dstore_r <= '0;
        kept_r   <= '0;
      end else begin
        phase_r  <= phase_nxt;
        tag_r    <= tag_nxt;
        left_r   <= left_nxt;
        accum_r  <= accum_nxt;
        dstore_r <= dstore_nxt;
        kept_r   <= kept_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/eitp_outq.sv
`default_nettype none

module eitp_outq
  import eitp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire eitp_push_t push,
  output logic            room,
  output logic            deq_valid,
  input  wire logic       deq_stall,
  output eitp_res_t       deq_res
);

  localparam int unsigned DEPTH = 4;

  eitp_res_t   mem [DEPTH];
  logic [1:0]  wr_r, wr_nxt;
  logic [1:0]  rd_r, rd_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign deq_valid = (cnt_r != 3'd0);
  assign pop       = deq_valid && !deq_stall;
  assign room      = (cnt_r <= 3'(DEPTH - 2));
  assign deq_res   = mem[rd_r];

  // Advance pointers and count
  always_comb begin
    wr_nxt  = wr_r + push.n;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push.n} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store up to two beats per cycle
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_r + 2'd1] <= push.r1;
    end
  end

endmodule

`default_nettype wire

FILE: src/eeprom_info_tlv_parser_unit.sv
// Channel   Valid      Stall       Payload
// input     in_valid   in_stall    in_data_byte, in_last_byte
// result    out_valid  out_stall   out_field_kind, out_value_major, out_value_minor,
//                                  out_imei_digits, out_digit_count, out_last_in_run
//
// One byte is taken per cycle while in_stall is low; its results are registered.
// A byte yields at most two result beats; the second only on the final byte of a
// buffer. Beats leave a four-entry result queue one a cycle while out_stall is low.
// in_stall is high while that queue has fewer than two free entries.
// Synchronous active-low reset returns the parser to the first header byte and
// empties the queue.
`default_nettype none

module eeprom_info_tlv_parser_unit
  import eitp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_field_kind,
  output logic [31:0]      out_value_major,
  output logic [15:0]      out_value_minor,
  output logic [63:0]      out_imei_digits,
  output logic [4:0]       out_digit_count,
  output logic             out_last_in_run
);

  logic       room;
  logic       accept;
  eitp_push_t push;
  eitp_res_t  res;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  // Parse one byte per beat
  eitp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .push      (push)
  );

  // Queue result beats
  eitp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .deq_valid (out_valid),
    .deq_stall (out_stall),
    .deq_res   (res)
  );

  assign out_field_kind  = res.kind;
  assign out_value_major = res.major;
  assign out_value_minor = res.minor;
  assign out_imei_digits = res.digits;
  assign out_digit_count = res.count;
  assign out_last_in_run = res.last;

endmodule

`default_nettype wire

FILE: tb/eitp_parse_check.sv
`timescale 1ns / 100ps

module eitp_parse_check
  import eitp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [3:0]  out_field_kind,
  input  wire logic [31:0] out_value_major,
  input  wire logic [15:0] out_value_minor,
  input  wire logic [63:0] out_imei_digits,
  input  wire logic [4:0]  out_digit_count,
  input  wire logic        out_last_in_run,
  output int               mismatches,
  output int               pending
);

  // Parser state as the block should hold it
  eitp_phase_t phase;
  eitp_tag_t   field_tag;
  logic [3:0]  bytes_left;
  logic [39:0] accum;
  logic [63:0] digit_store;
  logic [4:0]  digits_kept;

  // Fields still to come out, oldest first
  eitp_res_t expected_fields[$];
  eitp_res_t byte_fields[2];
  int        byte_field_n;

  function automatic eitp_res_t make_field(eitp_kind_t k, logic [31:0] major,
                                           logic [15:0] minor, logic [63:0] digits,
                                           logic [4:0] count);
    eitp_res_t r;
    r.kind   = k;
    r.major  = major;
    r.minor  = minor;
    r.digits = digits;
    r.count  = count;
    r.last   = 1'b0;
    return r;
  endfunction

  task automatic add_field(eitp_res_t r);
    if (byte_field_n < 2) begin
      byte_fields[byte_field_n] = r;
      byte_field_n++;
    end
  endtask

  task automatic clear_parser();
    phase       = PH_HDR0;
    field_tag   = TG_VERSION;
    bytes_left  = '0;
    accum       = '0;
    digit_store = '0;
    digits_kept = '0;
  endtask

  // Drop non-decimal nibbles, pack the rest from the top
  task automatic keep_digit(logic [3:0] d);
    if (d < BCD_LIMIT && digits_kept < MAX_DIGITS) begin
      digit_store[(15 - int'(digits_kept)) * 4 +: 4] = d;
      digits_kept++;
    end
  endtask

  task automatic report_field();
    case (field_tag)
      TG_VERSION:  add_field(make_field(K_VERSION, {24'h0, accum[7:0]}, '0, '0, '0));
      TG_PRODUCT:  add_field(make_field(K_PRODUCT, {8'h0, accum[39:16]}, accum[15:0],
                                        '0, '0));
      TG_TIME:     add_field(make_field(K_TIME, {accum[7:0], accum[15:8], accum[23:16],
                                                 accum[31:24]}, '0, '0, '0));
      TG_ASSEMBLY: add_field(make_field(K_ASSEMBLY, {8'h0, accum[39:16]}, accum[15:0],
                                        '0, '0));
      TG_IMEI:     add_field(make_field(K_IMEI, '0, '0, digit_store, digits_kept));
      default: ;
    endcase
  endtask

  // Advance the parser by one byte and queue the fields it yields
  task automatic parse_byte(logic [7:0] b, logic fin);
    eitp_res_t r;
    byte_field_n = 0;
    case (phase)
      PH_HDR0: begin
        if (b != HDR_BYTE0) begin
          add_field(make_field(K_BADVER, '0, '0, '0, '0));
          phase = PH_IGNORE;
        end else begin
          phase = PH_HDR1;
          if (fin) add_field(make_field(K_TRUNC, '0, '0, '0, '0));
        end
      end
      PH_HDR1: begin
        if (b != HDR_BYTE1) begin
          add_field(make_field(K_BADVER, '0, '0, '0, '0));
          phase = PH_IGNORE;
        end else begin
          add_field(make_field(K_VERSION, {24'h0, HDR_BYTE1}, '0, '0, '0));
          phase = PH_TAG;
          if (fin) add_field(make_field(K_ENDBUF, '0, '0, '0, '0));
        end
      end
      PH_TAG: begin
        accum       = '0;
        digit_store = '0;
        digits_kept = '0;
        case (b)
          TAG_BYTE_VERSION:  begin field_tag = TG_VERSION;  bytes_left = 4'd1; end
          TAG_BYTE_SKIP:     begin field_tag = TG_SKIP;     bytes_left = 4'd2; end
          TAG_BYTE_PRODUCT:  begin field_tag = TG_PRODUCT;  bytes_left = 4'd5; end
          TAG_BYTE_TIME:     begin field_tag = TG_TIME;     bytes_left = 4'd4; end
          TAG_BYTE_ASSEMBLY: begin field_tag = TG_ASSEMBLY; bytes_left = 4'd5; end
          TAG_BYTE_IMEI:     begin field_tag = TG_IMEI;     bytes_left = 4'd8; end
          default: bytes_left = '0;
        endcase
        if (bytes_left == 0) begin
          add_field(make_field(K_ENDTAG, '0, '0, '0, '0));
          phase = PH_IGNORE;
        end else begin
          phase = PH_PAYLOAD;
          if (fin) add_field(make_field(K_TRUNC, '0, '0, '0, '0));
        end
      end
      PH_PAYLOAD: begin
        accum = {accum[31:0], b};
        if (field_tag == TG_IMEI) begin
          keep_digit(b[7:4]);
          keep_digit(b[3:0]);
        end
        if (bytes_left > 0) bytes_left--;
        if (bytes_left == 0) begin
          report_field();
          phase = PH_TAG;
          if (fin) add_field(make_field(K_ENDBUF, '0, '0, '0, '0));
        end else if (fin) begin
          add_field(make_field(K_TRUNC, '0, '0, '0, '0));
        end
      end
      default: ;
    endcase
    for (int i = 0; i < byte_field_n; i++) begin
      r      = byte_fields[i];
      r.last = (i == byte_field_n - 1);
      expected_fields.push_back(r);
    end
    if (fin) clear_parser();
  endtask

  // Compare one result beat against the oldest expected field
  task automatic check_beat();
    eitp_res_t want;
    if (expected_fields.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected beat kind=%0d major=%h", $time, out_field_kind,
                 out_value_major);
    end else begin
      want = expected_fields.pop_front();
      if (want.kind !== out_field_kind || want.major !== out_value_major ||
          want.minor !== out_value_minor || want.digits !== out_imei_digits ||
          want.count !== out_digit_count || want.last !== out_last_in_run) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("%0t: exp kind=%0d major=%h minor=%h digits=%h n=%0d last=%b",
                 $time, want.kind, want.major, want.minor, want.digits, want.count,
                 want.last);
          $display(" / got kind=%0d major=%h minor=%h digits=%h n=%0d last=%b",
                   out_field_kind, out_value_major, out_value_minor,
                   out_imei_digits, out_digit_count, out_last_in_run);
        end
      end
    end
  endtask

  // Check results first: a byte's fields leave only after the result queue registers them
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      expected_fields.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) check_beat();
      if (in_valid && !in_stall) parse_byte(in_data_byte, in_last_byte);
    end
    pending = expected_fields.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import eitp_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_field_kind;
  logic [31:0] out_value_major;
  logic [15:0] out_value_minor;
  logic [63:0] out_imei_digits;
  logic [4:0]  out_digit_count;
  logic        out_last_in_run;

  int          mismatches;
  int          pending;
  int          gap_pct = 12;
  int          hold_pct = 52;
  int          items = 0;
  int          quiet_cycles = 0;
  logic [7:0]  image[$];

  eeprom_info_tlv_parser_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_field_kind (out_field_kind),
    .out_value_major(out_value_major),
    .out_value_minor(out_value_minor),
    .out_imei_digits(out_imei_digits),
    .out_digit_count(out_digit_count),
    .out_last_in_run(out_last_in_run)
  );

  eitp_parse_check parse_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_field_kind (out_field_kind),
    .out_value_major(out_value_major),
    .out_value_minor(out_value_minor),
    .out_imei_digits(out_imei_digits),
    .out_digit_count(out_digit_count),
    .out_last_in_run(out_last_in_run),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random back-pressure on the result side
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < hold_pct);
  end

  // End the run if no beat moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte, with random idle cycles first, and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Send the whole buffer and count its bytes
  task automatic play_image();
    items += image.size();
    for (int i = 0; i < image.size(); i++) send_byte(image[i], i == image.size() - 1);
    image.delete();
  endtask

  // Send a fixed buffer given most significant byte first
  task automatic play_seq(input logic [95:0] seq, input int len);
    for (int i = 0; i < len; i++) image.push_back(seq[(len - 1 - i) * 8 +: 8]);
    play_image();
  endtask

  function automatic logic [3:0] bcd_nibble();
    if ($urandom_range(0, 99) < 85) return 4'($urandom_range(0, 9));
    return 4'($urandom_range(10, 15));
  endfunction

  // Append one known field with random payload
  task automatic put_field();
    int n;
    case ($urandom_range(0, 5))
      0: begin image.push_back(TAG_BYTE_VERSION);  n = 1; end
      1: begin image.push_back(TAG_BYTE_SKIP);     n = 2; end
      2: begin image.push_back(TAG_BYTE_PRODUCT);  n = 5; end
      3: begin image.push_back(TAG_BYTE_TIME);     n = 4; end
      4: begin image.push_back(TAG_BYTE_ASSEMBLY); n = 5; end
      default: begin
        image.push_back(TAG_BYTE_IMEI);
        n = 0;
        repeat (8) image.push_back({bcd_nibble(), bcd_nibble()});
      end
    endcase
    repeat (n) image.push_back(8'($urandom));
  endtask

  // Mostly well-formed buffers, some cut short, some with an unknown tag, some noise
  task automatic random_image();
    int         r;
    int         cut;
    logic [7:0] t;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      image.push_back(HDR_BYTE0);
      image.push_back(HDR_BYTE1);
      repeat ($urandom_range(1, 5)) put_field();
      if ($urandom_range(0, 1)) begin
        cut = $urandom_range(1, image.size());
        while (image.size() > cut) void'(image.pop_back());
      end
    end else if (r < 85) begin
      image.push_back(HDR_BYTE0);
      image.push_back(HDR_BYTE1);
      repeat ($urandom_range(0, 3)) put_field();
      do t = 8'($urandom);
      while (t == TAG_BYTE_VERSION || t == TAG_BYTE_SKIP || t == TAG_BYTE_PRODUCT ||
             t == TAG_BYTE_TIME || t == TAG_BYTE_ASSEMBLY || t == TAG_BYTE_IMEI);
      image.push_back(t);
      repeat ($urandom_range(0, 4)) image.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 8)) image.push_back(8'($urandom));
      if ($urandom_range(0, 1)) image[0] = HDR_BYTE0;
    end
    play_image();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed buffers: header corner cases, IMEI nibble dropping, tag truncation,
    // unknown tag followed by ignored bytes
    play_seq(HDR_BYTE0, 1);
    play_seq(8'hFF, 1);
    play_seq({HDR_BYTE0, 8'h03, 8'h5A}, 3);
    play_seq({HDR_BYTE0, HDR_BYTE1}, 2);
    play_seq({HDR_BYTE0, HDR_BYTE1, TAG_BYTE_IMEI, 64'hFA0B_CDEF_9876_5432}, 11);
    play_seq({HDR_BYTE0, HDR_BYTE1, TAG_BYTE_SKIP}, 3);
    play_seq({HDR_BYTE0, HDR_BYTE1, 8'h7E, 8'h00}, 4);

    while (items < 320) random_image();
    gap_pct  = 52;
    hold_pct = 12;
    while (items < 630) random_image();
    gap_pct  = 0;
    hold_pct = 0;
    while (items < 940) random_image();
    in_valid <= 1'b0;

    // Drain, then give late or stray beats a chance to show up
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
